// ===== rtl/ppt_pkg.sv =====
// shared constants, mode codes and helper functions for the planar point transform
package ppt_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int ANG_FRAC     = 28;
  localparam int GUARD        = 16;
  localparam int GAIN_SH      = 30 - GUARD;

  localparam logic signed [30:0] GAIN = 31'(652032874);

  localparam logic [1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [1:0] MODE_ROTATE    = 2'd1;
  localparam logic [1:0] MODE_MIRROR    = 2'd2;
  localparam logic [1:0] MODE_REFLECT   = 2'd3;

  // angle reduction: 360 deg in Q.FRAC_BITS is 45 * 2^(FRAC_BITS+3)
  localparam int ANG_LO  = FRAC_BITS + 3;
  localparam int H_W     = 32 - ANG_LO;
  localparam int HU_W    = H_W + 1;
  localparam int H_BIAS  = 45 * ((2 ** (H_W - 1) + 44) / 45);
  localparam int RS      = HU_W + 6;
  localparam int RECIP   = (2 ** RS) / 45;
  localparam int RECIP_W = RS - 5;
  localparam int HPROD_W = HU_W + RECIP_W;
  localparam int HQ_W    = HPROD_W - RS;
  localparam int HREM_W  = 7;
  localparam int HMOD_W  = 6;

  localparam int ZW   = ANG_FRAC + 10;
  localparam int XG_W = 64;
  localparam int CW   = XG_W - GAIN_SH + 2;

  localparam logic signed [ZW-1:0] Z_HALF    = ZW'(180) <<< ANG_FRAC;
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90) <<< ANG_FRAC;

  // reflection divider
  localparam int NUM_W     = 97;
  localparam int DEN_W     = 64;
  localparam int QUO_W     = 35;
  localparam int DIV_LAT   = QUO_W + 1;
  localparam int REFL_PRE  = 7;
  localparam int NLVL      = REFL_PRE + DIV_LAT;
  // edges from the accepting edge to the edge that takes the result
  localparam int LATENCY   = NLVL + 2;
  localparam int LVL_DNEG  = 4;
  localparam int LVL_ROT   = 3 + CORDIC_STEPS + 3;

  function automatic logic signed [ZW-1:0] atan_q28(input logic [4:0] idx);
    case (idx)
      5'd0:  return ZW'(64'd12079595520);
      5'd1:  return ZW'(64'd7131001626);
      5'd2:  return ZW'(64'd3767825416);
      5'd3:  return ZW'(64'd1912607013);
      5'd4:  return ZW'(64'd960014949);
      5'd5:  return ZW'(64'd480475470);
      5'd6:  return ZW'(64'd240296363);
      5'd7:  return ZW'(64'd120155514);
      5'd8:  return ZW'(64'd60078674);
      5'd9:  return ZW'(64'd30039451);
      5'd10: return ZW'(64'd15019740);
      5'd11: return ZW'(64'd7509872);
      5'd12: return ZW'(64'd3754936);
      5'd13: return ZW'(64'd1877468);
      5'd14: return ZW'(64'd938734);
      5'd15: return ZW'(64'd469367);
      5'd16: return ZW'(64'd234684);
      5'd17: return ZW'(64'd117342);
      5'd18: return ZW'(64'd58671);
      5'd19: return ZW'(64'd29335);
      5'd20: return ZW'(64'd14668);
      5'd21: return ZW'(64'd7334);
      5'd22: return ZW'(64'd3667);
      5'd23: return ZW'(64'd1833);
      5'd24: return ZW'(64'd917);
      5'd25: return ZW'(64'd458);
      5'd26: return ZW'(64'd229);
      5'd27: return ZW'(64'd115);
      5'd28: return ZW'(64'd57);
      5'd29: return ZW'(64'd29);
      5'd30: return ZW'(64'd14);
      5'd31: return ZW'(64'd7);
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== rtl/planar_point_transform.sv =====
// top level: translate, rotate (cordic), mirror or reflect one q16.16 point per item
// path from the edge that takes start_i to done_o: the input register, 7 reflection set-up
// stages, 36 divider stages, output register
// throughput: one item every cycle, busy_o is always low; every mode takes the same path length
// the divider pipeline (one quotient bit per stage) sets the length
// reset clears the valid bits, the result strobe and the bad-line flag; no data is cleared
module planar_point_transform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] shift_y_i,
  input  logic signed [31:0] angle_deg_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] line_a_i,
  input  logic signed [31:0] line_b_i,
  input  logic signed [31:0] line_c_i,
  output logic               done_o,
  output logic signed [31:0] result_x_o,
  output logic signed [31:0] result_y_o,
  output logic               bad_line_o
);

  typedef struct packed {
    logic [1:0] mode;
    logic       bad;
    logic       dneg_x;
    logic       dneg_y;
  } side_t;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // input register
  logic               vld0_q;
  logic [1:0]         mode0_q;
  logic signed [31:0] px0_q, py0_q, sx0_q, sy0_q, ang0_q, cx0_q, cy0_q, a0_q, b0_q, c0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode0_q <= mode_i;
      px0_q   <= point_x_i;
      py0_q   <= point_y_i;
      sx0_q   <= shift_x_i;
      sy0_q   <= shift_y_i;
      ang0_q  <= angle_deg_i;
      cx0_q   <= center_x_i;
      cy0_q   <= center_y_i;
      a0_q    <= line_a_i;
      b0_q    <= line_b_i;
      c0_q    <= line_c_i;
    end
  end

  // side lane: mode, flags and the running result travel the whole length
  logic [ppt_pkg::NLVL:1] vld_q;
  side_t                  side_q   [1:ppt_pkg::NLVL];
  logic signed [31:0]     pass_x_q [1:ppt_pkg::NLVL];
  logic signed [31:0]     pass_y_q [1:ppt_pkg::NLVL];
  side_t                  side1_d;
  logic signed [31:0]     pass_x1_d, pass_y1_d;

  always_comb begin
    side1_d.mode   = mode0_q;
    side1_d.bad    = (mode0_q == ppt_pkg::MODE_REFLECT) && (a0_q == '0) && (b0_q == '0);
    side1_d.dneg_x = 1'b0;
    side1_d.dneg_y = 1'b0;
    case (mode0_q)
      ppt_pkg::MODE_TRANSLATE: begin
        pass_x1_d = ppt_pkg::sat32(40'(px0_q) + 40'(sx0_q));
        pass_y1_d = ppt_pkg::sat32(40'(py0_q) + 40'(sy0_q));
      end
      ppt_pkg::MODE_MIRROR: begin
        pass_x1_d = ppt_pkg::sat32((40'(cx0_q) <<< 1) - 40'(px0_q));
        pass_y1_d = ppt_pkg::sat32((40'(cy0_q) <<< 1) - 40'(py0_q));
      end
      ppt_pkg::MODE_ROTATE: begin
        // centre rides along until the rotated offset is added
        pass_x1_d = cx0_q;
        pass_y1_d = cy0_q;
      end
      default: begin
        pass_x1_d = px0_q;
        pass_y1_d = py0_q;
      end
    endcase
  end

  // ---------------- reflection set-up ----------------
  logic signed [63:0] pa1_q, pb1_q;
  logic [63:0]        aa1_q, bb1_q;
  logic [31:0]        absa1_q, absb1_q, absa2_q, absb2_q, absa3_q, absb3_q, absa4_q, absb4_q;
  logic               asgn1_q, bsgn1_q, asgn2_q, bsgn2_q, asgn3_q, bsgn3_q;
  logic signed [31:0] c1_q, c2_q;
  logic signed [64:0] s2_q;
  logic signed [65:0] n3_q;
  logic [63:0]        d2_q, d3_q, d4_q, d5_q, d6_q, d7_q;
  logic [63:0]        nmag4_q;
  logic [63:0]        plo_x5_q, phi_x5_q, plo_y5_q, phi_y5_q;
  logic [ppt_pkg::NUM_W-1:0] num_x6_q, num_y6_q, nn_x7_q, nn_y7_q;
  logic [ppt_pkg::QUO_W:0]   quo_x, quo_y;

  always_ff @(posedge clk_i) begin
    pa1_q   <= $signed(a0_q) * $signed(px0_q);
    pb1_q   <= $signed(b0_q) * $signed(py0_q);
    aa1_q   <= 64'($signed(a0_q) * $signed(a0_q));
    bb1_q   <= 64'($signed(b0_q) * $signed(b0_q));
    absa1_q <= a0_q[31] ? 32'(-a0_q) : 32'(a0_q);
    absb1_q <= b0_q[31] ? 32'(-b0_q) : 32'(b0_q);
    asgn1_q <= a0_q[31];
    bsgn1_q <= b0_q[31];
    c1_q    <= c0_q;

    s2_q    <= 65'(pa1_q) + 65'(pb1_q);
    d2_q    <= aa1_q + bb1_q;
    c2_q    <= c1_q;
    absa2_q <= absa1_q;
    absb2_q <= absb1_q;
    asgn2_q <= asgn1_q;
    bsgn2_q <= bsgn1_q;

    n3_q    <= 66'(s2_q) + (66'(c2_q) <<< ppt_pkg::FRAC_BITS);
    d3_q    <= d2_q;
    absa3_q <= absa2_q;
    absb3_q <= absb2_q;
    asgn3_q <= asgn2_q;
    bsgn3_q <= bsgn2_q;

    nmag4_q <= n3_q[65] ? 64'(-n3_q) : n3_q[63:0];
    d4_q    <= d3_q;
    absa4_q <= absa3_q;
    absb4_q <= absb3_q;

    // 32 x 64 products as two 32 x 32 halves
    plo_x5_q <= 64'(absa4_q) * 64'(nmag4_q[31:0]);
    phi_x5_q <= 64'(absa4_q) * 64'(nmag4_q[63:32]);
    plo_y5_q <= 64'(absb4_q) * 64'(nmag4_q[31:0]);
    phi_y5_q <= 64'(absb4_q) * 64'(nmag4_q[63:32]);
    d5_q     <= d4_q;

    num_x6_q <= ppt_pkg::NUM_W'({phi_x5_q, 32'd0} + 96'(plo_x5_q)) << 1;
    num_y6_q <= ppt_pkg::NUM_W'({phi_y5_q, 32'd0} + 96'(plo_y5_q)) << 1;
    d6_q     <= d5_q;

    // add half the divisor for round to nearest
    nn_x7_q  <= num_x6_q + ppt_pkg::NUM_W'(d6_q >> 1);
    nn_y7_q  <= num_y6_q + ppt_pkg::NUM_W'(d6_q >> 1);
    d7_q     <= d6_q;
  end

  ppt_div u_div_x (
    .clk_i (clk_i),
    .num_i (nn_x7_q),
    .den_i (d7_q),
    .quo_o (quo_x)
  );

  ppt_div u_div_y (
    .clk_i (clk_i),
    .num_i (nn_y7_q),
    .den_i (d7_q),
    .quo_o (quo_y)
  );

  // ---------------- rotation ----------------
  logic signed [32:0]                 dx1_q, dy1_q;
  logic [ppt_pkg::HU_W-1:0]           hu_d, hu1_q;
  logic [ppt_pkg::HPROD_W-1:0]        hprod1_q;
  logic [ppt_pkg::ANG_LO-1:0]         lo1_q, lo2_q;
  logic signed [ppt_pkg::XG_W-1:0]    xg2_q, yg2_q;
  logic [ppt_pkg::HQ_W-1:0]           hq;
  logic [ppt_pkg::HU_W-1:0]           h45;
  logic [ppt_pkg::HREM_W-1:0]         hrem;
  logic [ppt_pkg::HMOD_W-1:0]         hmod2_q;
  logic signed [ppt_pkg::ZW-1:0]      zr, zh, zf;
  logic                               flip_d;

  logic signed [ppt_pkg::CW-1:0]      xc_q [0:ppt_pkg::CORDIC_STEPS];
  logic signed [ppt_pkg::CW-1:0]      yc_q [0:ppt_pkg::CORDIC_STEPS];
  logic signed [ppt_pkg::ZW-1:0]      zc_q [0:ppt_pkg::CORDIC_STEPS];
  logic [ppt_pkg::CORDIC_STEPS:0]     flip_q;

  logic [ppt_pkg::CW-1:0]             rmag_x_q, rmag_y_q;
  logic                               rsgn_x_q, rsgn_y_q;
  logic signed [ppt_pkg::CW-ppt_pkg::GUARD:0] rv_x_q, rv_y_q;
  logic signed [ppt_pkg::CW-1:0]      xe, ye;

  assign hu_d = ppt_pkg::HU_W'($signed(ang0_q[31:ppt_pkg::ANG_LO]))
              + ppt_pkg::HU_W'(ppt_pkg::H_BIAS);

  // floor quotient by 45 can be one low: a single correction fixes it
  assign hq   = hprod1_q[ppt_pkg::HPROD_W-1:ppt_pkg::RS];
  assign h45  = ppt_pkg::HU_W'({hq, 5'd0}) + ppt_pkg::HU_W'({hq, 3'd0})
              + ppt_pkg::HU_W'({hq, 2'd0}) + ppt_pkg::HU_W'(hq);
  assign hrem = ppt_pkg::HREM_W'(hu1_q - h45);

  always_comb begin
    zr     = ppt_pkg::ZW'({hmod2_q, lo2_q}) <<< (ppt_pkg::ANG_FRAC - ppt_pkg::FRAC_BITS);
    zh     = (zr > ppt_pkg::Z_HALF) ? zr - (ppt_pkg::Z_HALF <<< 1) : zr;
    flip_d = 1'b0;
    zf     = zh;
    if (zh > ppt_pkg::Z_QUARTER) begin
      zf     = zh - ppt_pkg::Z_HALF;
      flip_d = 1'b1;
    end else if (zh < -ppt_pkg::Z_QUARTER) begin
      zf     = zh + ppt_pkg::Z_HALF;
      flip_d = 1'b1;
    end
  end

  assign xe = xc_q[ppt_pkg::CORDIC_STEPS];
  assign ye = yc_q[ppt_pkg::CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    dx1_q    <= 33'(px0_q) - 33'(cx0_q);
    dy1_q    <= 33'(py0_q) - 33'(cy0_q);
    hu1_q    <= hu_d;
    hprod1_q <= ppt_pkg::HPROD_W'(hu_d * ppt_pkg::RECIP_W'(ppt_pkg::RECIP));
    lo1_q    <= ang0_q[ppt_pkg::ANG_LO-1:0];

    xg2_q    <= $signed(dx1_q) * ppt_pkg::GAIN;
    yg2_q    <= $signed(dy1_q) * ppt_pkg::GAIN;
    hmod2_q  <= (hrem >= ppt_pkg::HREM_W'(45)) ? ppt_pkg::HMOD_W'(hrem - ppt_pkg::HREM_W'(45))
                                               : ppt_pkg::HMOD_W'(hrem);
    lo2_q    <= lo1_q;

    xc_q[0]   <= ppt_pkg::CW'($signed(xg2_q[ppt_pkg::XG_W-1:ppt_pkg::GAIN_SH]));
    yc_q[0]   <= ppt_pkg::CW'($signed(yg2_q[ppt_pkg::XG_W-1:ppt_pkg::GAIN_SH]));
    zc_q[0]   <= zf;
    flip_q[0] <= flip_d;

    for (int i = 0; i < ppt_pkg::CORDIC_STEPS; i++) begin
      flip_q[i+1] <= flip_q[i];
      if (zc_q[i] >= 0) begin
        xc_q[i+1] <= xc_q[i] - (yc_q[i] >>> i);
        yc_q[i+1] <= yc_q[i] + (xc_q[i] >>> i);
        zc_q[i+1] <= zc_q[i] - ppt_pkg::atan_q28(5'(i));
      end else begin
        xc_q[i+1] <= xc_q[i] + (yc_q[i] >>> i);
        yc_q[i+1] <= yc_q[i] - (xc_q[i] >>> i);
        zc_q[i+1] <= zc_q[i] + ppt_pkg::atan_q28(5'(i));
      end
    end

    // drop guard bits, ties away from zero; a fold by 180 deg flips the sign
    rmag_x_q <= (xe[ppt_pkg::CW-1] ? ppt_pkg::CW'(-xe) : ppt_pkg::CW'(xe))
              + (ppt_pkg::CW'(1) << (ppt_pkg::GUARD - 1));
    rmag_y_q <= (ye[ppt_pkg::CW-1] ? ppt_pkg::CW'(-ye) : ppt_pkg::CW'(ye))
              + (ppt_pkg::CW'(1) << (ppt_pkg::GUARD - 1));
    rsgn_x_q <= xe[ppt_pkg::CW-1] ^ flip_q[ppt_pkg::CORDIC_STEPS];
    rsgn_y_q <= ye[ppt_pkg::CW-1] ^ flip_q[ppt_pkg::CORDIC_STEPS];

    rv_x_q <= rsgn_x_q ? -$signed({1'b0, rmag_x_q[ppt_pkg::CW-1:ppt_pkg::GUARD]})
                       :  $signed({1'b0, rmag_x_q[ppt_pkg::CW-1:ppt_pkg::GUARD]});
    rv_y_q <= rsgn_y_q ? -$signed({1'b0, rmag_y_q[ppt_pkg::CW-1:ppt_pkg::GUARD]})
                       :  $signed({1'b0, rmag_y_q[ppt_pkg::CW-1:ppt_pkg::GUARD]});
  end

  // ---------------- side lane ----------------
  side_t              side_dn_d;
  logic signed [31:0] rot_x_d, rot_y_d;

  always_comb begin
    side_dn_d        = side_q[ppt_pkg::LVL_DNEG-1];
    side_dn_d.dneg_x = asgn3_q ^ n3_q[65];
    side_dn_d.dneg_y = bsgn3_q ^ n3_q[65];
    if (side_q[ppt_pkg::LVL_ROT-1].mode == ppt_pkg::MODE_ROTATE) begin
      rot_x_d = ppt_pkg::sat32(40'(rv_x_q) + 40'(pass_x_q[ppt_pkg::LVL_ROT-1]));
      rot_y_d = ppt_pkg::sat32(40'(rv_y_q) + 40'(pass_y_q[ppt_pkg::LVL_ROT-1]));
    end else begin
      rot_x_d = pass_x_q[ppt_pkg::LVL_ROT-1];
      rot_y_d = pass_y_q[ppt_pkg::LVL_ROT-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ppt_pkg::NLVL-1:1], vld0_q};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[1]   <= side1_d;
    pass_x_q[1] <= pass_x1_d;
    pass_y_q[1] <= pass_y1_d;
    for (int k = 2; k <= ppt_pkg::NLVL; k++) begin
      if (k == ppt_pkg::LVL_DNEG) begin
        side_q[k] <= side_dn_d;
      end else begin
        side_q[k] <= side_q[k-1];
      end
      if (k == ppt_pkg::LVL_ROT) begin
        pass_x_q[k] <= rot_x_d;
        pass_y_q[k] <= rot_y_d;
      end else begin
        pass_x_q[k] <= pass_x_q[k-1];
        pass_y_q[k] <= pass_y_q[k-1];
      end
    end
  end

  // ---------------- output stage ----------------
  side_t              side_e;
  logic signed [31:0] px_e, py_e, rx_d, ry_d;
  logic signed [39:0] sum_x, sum_y;

  assign side_e = side_q[ppt_pkg::NLVL];
  assign px_e   = pass_x_q[ppt_pkg::NLVL];
  assign py_e   = pass_y_q[ppt_pkg::NLVL];

  always_comb begin
    sum_x = side_e.dneg_x ? 40'(px_e) + $signed(40'(quo_x)) : 40'(px_e) - $signed(40'(quo_x));
    sum_y = side_e.dneg_y ? 40'(py_e) + $signed(40'(quo_y)) : 40'(py_e) - $signed(40'(quo_y));
    if (side_e.mode == ppt_pkg::MODE_REFLECT && !side_e.bad) begin
      rx_d = ppt_pkg::sat32(sum_x);
      ry_d = ppt_pkg::sat32(sum_y);
    end else begin
      rx_d = px_e;
      ry_d = py_e;
    end
  end

  logic               done_q, bad_q;
  logic signed [31:0] res_x_q, res_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      bad_q  <= 1'b0;
    end else begin
      done_q <= vld_q[ppt_pkg::NLVL];
      bad_q  <= vld_q[ppt_pkg::NLVL] & side_e.bad;
    end
  end

  always_ff @(posedge clk_i) begin
    res_x_q <= rx_d;
    res_y_q <= ry_d;
  end

  assign done_o     = done_q;
  assign bad_line_o = bad_q;
  assign result_x_o = res_x_q;
  assign result_y_o = res_y_q;

endmodule

// ===== rtl/ppt_div.sv =====
// pipelined restoring divider, one quotient bit per stage, quotient clamped on overflow
module ppt_div (
  input  logic                        clk_i,
  input  logic [ppt_pkg::NUM_W-1:0]   num_i,
  input  logic [ppt_pkg::DEN_W-1:0]   den_i,
  output logic [ppt_pkg::QUO_W:0]     quo_o
);

  logic [ppt_pkg::QUO_W:0]   ovf_q;
  logic [ppt_pkg::DEN_W-1:0] rem_q [0:ppt_pkg::QUO_W];
  logic [ppt_pkg::DEN_W-1:0] den_q [0:ppt_pkg::QUO_W];
  logic [ppt_pkg::QUO_W-1:0] low_q [0:ppt_pkg::QUO_W];
  logic [ppt_pkg::QUO_W-1:0] quo_q [0:ppt_pkg::QUO_W];

  logic [ppt_pkg::DEN_W:0]   trial [1:ppt_pkg::QUO_W];
  logic [ppt_pkg::QUO_W:1]   take;

  always_comb begin
    for (int k = 1; k <= ppt_pkg::QUO_W; k++) begin
      trial[k] = {rem_q[k-1], low_q[k-1][ppt_pkg::QUO_W-1]};
      take[k]  = trial[k] >= {1'b0, den_q[k-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    // quotient would not fit: any value this large saturates downstream
    ovf_q[0] <= (ppt_pkg::DEN_W + ppt_pkg::QUO_W)'(num_i) >=
                {den_i, {ppt_pkg::QUO_W{1'b0}}};
    rem_q[0] <= ppt_pkg::DEN_W'(num_i[ppt_pkg::NUM_W-1:ppt_pkg::QUO_W]);
    low_q[0] <= num_i[ppt_pkg::QUO_W-1:0];
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    for (int k = 1; k <= ppt_pkg::QUO_W; k++) begin
      ovf_q[k] <= ovf_q[k-1];
      den_q[k] <= den_q[k-1];
      low_q[k] <= low_q[k-1] << 1;
      quo_q[k] <= {quo_q[k-1][ppt_pkg::QUO_W-2:0], take[k]};
      if (take[k]) begin
        rem_q[k] <= ppt_pkg::DEN_W'(trial[k] - {1'b0, den_q[k-1]});
      end else begin
        rem_q[k] <= ppt_pkg::DEN_W'(trial[k]);
      end
    end
  end

  assign quo_o = ovf_q[ppt_pkg::QUO_W] ? {1'b1, {ppt_pkg::QUO_W{1'b0}}}
                                        : {1'b0, quo_q[ppt_pkg::QUO_W]};

endmodule

// ===== rtl/ppt_checker.sv =====
// port-level checks for the planar point transform, bound to the top level
module ppt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [1:0]         mode_i,
  input logic signed [31:0] point_x_i,
  input logic signed [31:0] shift_x_i,
  input logic signed [31:0] line_a_i,
  input logic signed [31:0] line_b_i,
  input logic signed [31:0] result_x_o,
  input logic               bad_line_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(ppt_pkg::LATENCY) done_o)
    else $error("result strobe missing after transfer");

  a_bad_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_line_o |-> done_o)
    else $error("bad_line_o without result strobe");

  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && mode_i == ppt_pkg::MODE_REFLECT && line_a_i == '0 && line_b_i == '0
    |-> ##(ppt_pkg::LATENCY)
    (bad_line_o && result_x_o == $past(point_x_i, ppt_pkg::LATENCY)))
    else $error("degenerate line must flag and return the point");

  a_zero_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && mode_i == ppt_pkg::MODE_TRANSLATE && shift_x_i == '0
    |-> ##(ppt_pkg::LATENCY) result_x_o == $past(point_x_i, ppt_pkg::LATENCY))
    else $error("zero translation changed x");

endmodule

bind planar_point_transform ppt_checker u_ppt_checker (.*);

// ===== verif/planar_point_transform_check.sv =====
// checker for the planar point transform: predicts each transfer and compares results
`timescale 1ns / 100ps

module planar_point_transform_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] shift_y_i,
  input  logic signed [31:0] angle_deg_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] line_a_i,
  input  logic signed [31:0] line_b_i,
  input  logic signed [31:0] line_c_i,
  input  logic               done_i,
  input  logic signed [31:0] result_x_i,
  input  logic signed [31:0] result_y_i,
  input  logic               bad_line_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output logic               moved_o
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               bad;
  } point_res_t;

  localparam longint ATAN_DEG_Q28 [32] = '{
    64'sd12079595520, 64'sd7131001626, 64'sd3767825416, 1912607013, 960014949, 480475470,
    240296363, 120155514, 60078674, 30039451, 15019740, 7509872,
    3754936, 1877468, 938734, 469367, 234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  point_res_t transformed_q[$];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint round_guard(input longint v);
    longint h;
    h = 64'sd1 <<< 15;
    if (v >= 0) return (v + h) >>> 16;
    return -((-v + h) >>> 16);
  endfunction

  function automatic longint mirror_coord(input longint p, input longint coef,
                                          input bit nneg, input bit [63:0] nmag,
                                          input bit [63:0] den);
    bit [127:0] num, quo;
    longint     cmag;
    bit         dneg;
    cmag = coef < 0 ? -coef : coef;
    num  = 128'(2 * cmag) * 128'(nmag);
    quo  = (num + 128'(den >> 1)) / 128'(den);
    dneg = (coef < 0) != nneg;
    if (quo > (128'd1 << 40)) return dneg ? (64'sd1 <<< 41) : -(64'sd1 <<< 41);
    return dneg ? p + longint'(quo[63:0]) : p - longint'(quo[63:0]);
  endfunction

  function automatic point_res_t transform_point(
      input logic [1:0] mode, input longint px, input longint py,
      input longint sx, input longint sy, input longint ang,
      input longint cx, input longint cy,
      input longint la, input longint lb, input longint lc);
    point_res_t       res;
    longint           rx, ry, r, z, x, y, xs, ys;
    bit               flip;
    logic signed [127:0] n;
    bit [127:0]       nabs;
    bit [63:0]        den;
    rx = px; ry = py; res.bad = 1'b0; flip = 1'b0;
    case (mode)
      ppt_pkg::MODE_TRANSLATE: begin
        rx = px + sx; ry = py + sy;
      end
      ppt_pkg::MODE_ROTATE: begin
        r = ang % (64'sd360 <<< 16);
        if (r < 0) r += 64'sd360 <<< 16;
        z = r <<< 12;
        if (z > (64'sd180 <<< 28)) z -= 64'sd360 <<< 28;
        if (z > (64'sd90 <<< 28)) begin
          z -= 64'sd180 <<< 28; flip = 1'b1;
        end else if (z < -(64'sd90 <<< 28)) begin
          z += 64'sd180 <<< 28; flip = 1'b1;
        end
        x = ((px - cx) * 64'sd652032874) >>> 14;
        y = ((py - cy) * 64'sd652032874) >>> 14;
        for (int i = 0; i < 24; i++) begin
          xs = x >>> i; ys = y >>> i;
          if (z >= 0) begin
            x -= ys; y += xs; z -= ATAN_DEG_Q28[i];
          end else begin
            x += ys; y -= xs; z += ATAN_DEG_Q28[i];
          end
        end
        if (flip) begin
          x = -x; y = -y;
        end
        rx = round_guard(x) + cx; ry = round_guard(y) + cy;
      end
      ppt_pkg::MODE_MIRROR: begin
        rx = 2 * cx - px; ry = 2 * cy - py;
      end
      default: begin
        if (la == 0 && lb == 0) begin
          res.bad = 1'b1;
        end else begin
          n = 128'(la) * 128'(px) + 128'(lb) * 128'(py) + 128'(lc) * 128'sd65536;
          nabs = n[127] ? -n : n;
          den = 64'(la * la) + 64'(lb * lb);
          rx = mirror_coord(px, la, n[127], nabs[63:0], den);
          ry = mirror_coord(py, lb, n[127], nabs[63:0], den);
        end
      end
    endcase
    res.x = clamp32(rx); res.y = clamp32(ry);
    return res;
  endfunction

  assign pending_o = transformed_q.size();

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    point_res_t want;
    moved_o <= rst_ni && ((start_i && !busy_i) || done_i);
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        transformed_q.push_back(transform_point(mode_i, point_x_i, point_y_i,
          shift_x_i, shift_y_i, angle_deg_i, center_x_i, center_y_i,
          line_a_i, line_b_i, line_c_i));
      end
      if (done_i) begin
        if (transformed_q.size() == 0) begin
          $display("%0t: result with nothing expected: x %h y %h bad %b", $time,
                   result_x_i, result_y_i, bad_line_i);
          fail_count_o++;
        end else begin
          want = transformed_q.pop_front();
          if (want.x !== result_x_i) begin
            $display("%0t: result_x expected %h actual %h", $time, want.x, result_x_i);
            fail_count_o++;
          end
          if (want.y !== result_y_i) begin
            $display("%0t: result_y expected %h actual %h", $time, want.y, result_y_i);
            fail_count_o++;
          end
          if (want.bad !== bad_line_i) begin
            $display("%0t: bad_line expected %b actual %b", $time, want.bad, bad_line_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/planar_point_transform_test.sv =====
// testbench top: drives point transfers into the transform and gives the verdict
`timescale 1ns / 100ps

module planar_point_transform_test;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy, done, bad_line;
  logic [1:0]         mode = '0;
  logic signed [31:0] point_x = '0, point_y = '0, shift_x = '0, shift_y = '0;
  logic signed [31:0] angle_deg = '0, center_x = '0, center_y = '0;
  logic signed [31:0] line_a = '0, line_b = '0, line_c = '0;
  logic signed [31:0] result_x, result_y;
  int                 fail_count, pending, idle_pct, quiet_cycles;
  logic               moved;

  always #10 clk = ~clk;

  planar_point_transform dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .mode_i(mode),
    .point_x_i(point_x), .point_y_i(point_y), .shift_x_i(shift_x), .shift_y_i(shift_y),
    .angle_deg_i(angle_deg), .center_x_i(center_x), .center_y_i(center_y),
    .line_a_i(line_a), .line_b_i(line_b), .line_c_i(line_c),
    .done_o(done), .result_x_o(result_x), .result_y_o(result_y), .bad_line_o(bad_line)
  );

  planar_point_transform_check check (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .mode_i(mode),
    .point_x_i(point_x), .point_y_i(point_y), .shift_x_i(shift_x), .shift_y_i(shift_y),
    .angle_deg_i(angle_deg), .center_x_i(center_x), .center_y_i(center_y),
    .line_a_i(line_a), .line_b_i(line_b), .line_c_i(line_c),
    .done_i(done), .result_x_i(result_x), .result_y_i(result_y), .bad_line_i(bad_line),
    .fail_count_o(fail_count), .pending_o(pending), .moved_o(moved)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (moved || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'(int'($urandom_range(0, 2)) - 1);
      3, 4, 5: return $urandom;
      default: return 32'(int'($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
    endcase
  endfunction

  task automatic load_item(input logic [1:0] m, input logic signed [31:0] px,
                           input logic signed [31:0] py, input logic signed [31:0] p0,
                           input logic signed [31:0] p1, input logic signed [31:0] p2);
    mode = m; point_x = px; point_y = py;
    shift_x = p0; shift_y = p1; angle_deg = p2;
    center_x = p0; center_y = p1;
    line_a = p0; line_b = p1; line_c = p2;
  endtask

  // called at a falling edge with the item on the ports; returns at the falling
  // edge after the transfer, or after the idle cycles drawn for it
  task automatic send_item();
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    // each following cycle is idle with the phase's odds
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic random_item();
    logic [1:0] m;
    m = 2'($urandom_range(0, 3));
    load_item(m, pick_q16(), pick_q16(), pick_q16(), pick_q16(), pick_q16());
    // with even odds, shift and angle get noise of their own, apart from centre and line
    if ($urandom_range(0, 1)) begin
      shift_x = $urandom; shift_y = $urandom; angle_deg = $urandom;
    end
    if (m == ppt_pkg::MODE_ROTATE && $urandom_range(0, 2) == 0)
      angle_deg = 32'(int'($urandom_range(0, 16)) * 45 - 360) <<< 16;
    if (m == ppt_pkg::MODE_REFLECT) begin
      case ($urandom_range(0, 5))
        0: begin
          line_a = '0; line_b = '0;
        end
        1: line_a = '0;
        2: line_b = '0;
        default: ;
      endcase
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes and each mode
    load_item(ppt_pkg::MODE_TRANSLATE, 32'sh7fffffff, 32'sh80000000, 32'sh00000001,
              -32'sd1, 0);
    send_item();
    load_item(ppt_pkg::MODE_TRANSLATE, 32'sh00010000, -32'sh00020000, 32'sh00030000,
              32'sh00008000, 0);
    send_item();
    load_item(ppt_pkg::MODE_ROTATE, 32'sh00010000, 0, 0, 0, 32'sh005a0000);
    send_item();
    load_item(ppt_pkg::MODE_ROTATE, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000);
    send_item();
    load_item(ppt_pkg::MODE_ROTATE, 32'sh00050000, 32'sh00030000, 32'sh00010000,
              -32'sh00010000, 32'sh7fffffff);
    send_item();
    load_item(ppt_pkg::MODE_ROTATE, 32'sh00020000, 0, 0, 0, -32'sh00b40000);
    send_item();
    load_item(ppt_pkg::MODE_ROTATE, 32'sh00020000, 32'sh00010000, 0, 0, 32'sh01680000);
    send_item();
    load_item(ppt_pkg::MODE_MIRROR, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 0);
    send_item();
    load_item(ppt_pkg::MODE_MIRROR, 32'sh00010000, 32'sh00020000, 0, 0, 0);
    send_item();
    load_item(ppt_pkg::MODE_REFLECT, 32'sh00030000, 32'sh00040000, 0, 0, 32'sh00050000);
    send_item();
    load_item(ppt_pkg::MODE_REFLECT, 32'sh00030000, 32'sh00040000, 32'sh00010000,
              32'sh00010000, 0);
    send_item();
    load_item(ppt_pkg::MODE_REFLECT, 32'sh7fffffff, 32'sh80000000, 1, 32'sh80000000,
              32'sh7fffffff);
    send_item();
    load_item(ppt_pkg::MODE_REFLECT, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
              32'sh7fffffff, 32'sh80000000);
    send_item();
    load_item(ppt_pkg::MODE_REFLECT, 32'sh00020000, -32'sh00010000, 1, -1, 32'sh7fffffff);
    send_item();
    start = 1'b0;

    // hold off until the pipe has drained
    while (pending != 0) @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 45;
        2: idle_pct = 31;
        default: idle_pct = 0;
      endcase
      repeat (385) begin
        random_item();
        send_item();
      end
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
